>>> rtl/dpp_pkg.sv
// Shared types and constants for the depth pixel to point back-projection block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dpp_pkg;

    localparam int unsigned DEPTH_W   = 16;
    localparam int unsigned PIXIDX_W  = 8;
    localparam int unsigned COORD_W   = 22;
    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned OFFSET_W  = 11;
    localparam int unsigned CENTRE_W  = 15;
    localparam int unsigned INVF_W    = 24;
    localparam int unsigned DMAX_W    = 16;
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned APB_DW    = 32;

    // full-image pixel (offset + window index) and its Q12.4 form
    localparam int unsigned PIXEL_W   = 12;
    localparam int unsigned P16_W     = PIXEL_W + 4;
    // |pixel - centre| * 1/f, then times depth
    localparam int unsigned PM_W      = P16_W + INVF_W;
    localparam int unsigned FULL_W    = PM_W + DEPTH_W;
    localparam int unsigned QUOT_W    = FULL_W - INVF_W;
    // depth * 255 and the display quotient (one extra bit flags overflow)
    localparam int unsigned NUM_W     = DEPTH_W + 8;
    localparam int unsigned DQ_W      = LEVEL_W + 1;

    localparam logic [DEPTH_W-1:0] MIN_VALID_DEPTH = 16'd100;
    localparam logic [QUOT_W-1:0]  POS_MAX_MAG     = 32'd2097151;
    localparam logic [QUOT_W-1:0]  NEG_MAX_MAG     = 32'd2097152;

    localparam logic [OFFSET_W-1:0] X_OFFSET_RST    = 11'd116;
    localparam logic [OFFSET_W-1:0] Y_OFFSET_RST    = 11'd93;
    localparam logic [CENTRE_W-1:0] CENTER_X_RST    = 15'd15360;
    localparam logic [CENTRE_W-1:0] CENTER_Y_RST    = 15'd8640;
    localparam logic [INVF_W-1:0]   INV_FOCAL_X_RST = 24'd15828;
    localparam logic [INVF_W-1:0]   INV_FOCAL_Y_RST = 24'd15828;
    localparam logic [DMAX_W-1:0]   DISPLAY_MAX_RST = 16'd4096;

    typedef enum logic [2:0] {
        REG_X_OFFSET    = 3'd0,
        REG_Y_OFFSET    = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_INV_FOCAL_X = 3'd4,
        REG_INV_FOCAL_Y = 3'd5,
        REG_DISPLAY_MAX = 3'd6
    } t_reg_idx;

    // partial state of the display-level restoring divider
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DQ_W-1:0]  quo;
    } t_div;

endpackage

`default_nettype wire

>>> rtl/dpp_in_if.sv
// Pixel input channel: valid/ready handshake with depth and window position.
// Depends on dpp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dpp_in_if;
    import dpp_pkg::*;

    logic                valid;
    logic                ready;
    logic [DEPTH_W-1:0]  depth_mm;
    logic [PIXIDX_W-1:0] win_col;
    logic [PIXIDX_W-1:0] win_row;

    modport source (output valid, depth_mm, win_col, win_row, input ready);
    modport sink   (input valid, depth_mm, win_col, win_row, output ready);
endinterface

`default_nettype wire

>>> rtl/dpp_out_if.sv
// Point output channel: valid/ready handshake with coordinates and display level.
// Depends on dpp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dpp_out_if;
    import dpp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [DEPTH_W-1:0]        pos_z;
    logic                      point_valid;
    logic [LEVEL_W-1:0]        display_level;

    modport source (output valid, pos_x, pos_y, pos_z, point_valid, display_level,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, point_valid, display_level,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/depth_pixel_to_point.sv
// Depth pixel to 3-D point: pinhole back-projection pipeline with APB registers.
// Depends on dpp_pkg, dpp_in_if and dpp_out_if.
//
//  Channel   Direction  Transaction
//  i_pix     in         one depth sample with its window column and row
//  o_pt      out        X, Y (1/16 mm), Z (mm), point_valid, display level
//  APB       in/out     register write/read, 4-byte stride, pready tied high
//
// Four register stages, one pixel per cycle sustained while o_pt.ready stays
// high. The two multiplies (distance*1/f, then *depth) and the nine-bit display
// divider, three quotient bits per stage, set the depth.
// Each stage holds independently: a stalled output fills bubbles upstream
// before i_pix.ready drops. Synchronous active-low reset clears valids and
// loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module depth_pixel_to_point (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    dpp_in_if.sink                       i_pix,
    dpp_out_if.source                    o_pt,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [dpp_pkg::APB_AW-1:0]   paddr,
    input  wire  [dpp_pkg::APB_DW-1:0]   pwdata,
    output logic [dpp_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import dpp_pkg::*;

    // ---------------------------------------------------------------- registers
    logic [OFFSET_W-1:0] r_x_offset, r_y_offset;
    logic [CENTRE_W-1:0] r_center_x, r_center_y;
    logic [INVF_W-1:0]   r_inv_focal_x, r_inv_focal_y;
    logic [DMAX_W-1:0]   r_display_max;
    t_reg_idx            reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset    <= X_OFFSET_RST;
            r_y_offset    <= Y_OFFSET_RST;
            r_center_x    <= CENTER_X_RST;
            r_center_y    <= CENTER_Y_RST;
            r_inv_focal_x <= INV_FOCAL_X_RST;
            r_inv_focal_y <= INV_FOCAL_Y_RST;
            r_display_max <= DISPLAY_MAX_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_X_OFFSET:    r_x_offset    <= pwdata[OFFSET_W-1:0];
                REG_Y_OFFSET:    r_y_offset    <= pwdata[OFFSET_W-1:0];
                REG_CENTER_X:    r_center_x    <= pwdata[CENTRE_W-1:0];
                REG_CENTER_Y:    r_center_y    <= pwdata[CENTRE_W-1:0];
                REG_INV_FOCAL_X: r_inv_focal_x <= pwdata[INVF_W-1:0];
                REG_INV_FOCAL_Y: r_inv_focal_y <= pwdata[INVF_W-1:0];
                REG_DISPLAY_MAX: r_display_max <= pwdata[DMAX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_X_OFFSET:    prdata = APB_DW'(r_x_offset);
            REG_Y_OFFSET:    prdata = APB_DW'(r_y_offset);
            REG_CENTER_X:    prdata = APB_DW'(r_center_x);
            REG_CENTER_Y:    prdata = APB_DW'(r_center_y);
            REG_INV_FOCAL_X: prdata = APB_DW'(r_inv_focal_x);
            REG_INV_FOCAL_Y: prdata = APB_DW'(r_inv_focal_y);
            REG_DISPLAY_MAX: prdata = APB_DW'(r_display_max);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- helpers
    // three restoring-division steps, quotient bits hi down to hi-2
    function automatic t_div div3(input t_div a, input logic [DMAX_W-1:0] d,
                                  input logic [3:0] hi);
        t_div             r;
        logic [NUM_W:0]   sd;
        logic [3:0]       k;
        r = a;
        for (int i = 0; i < 3; i++) begin
            k  = hi - 4'(i);
            sd = (NUM_W+1)'(d) << k;
            if ({1'b0, r.rem} >= sd) begin
                r.rem    = r.rem - sd[NUM_W-1:0];
                r.quo[k] = 1'b1;
            end
        end
        return r;
    endfunction

    // truncated quotient to saturated 22-bit two's complement
    function automatic logic [COORD_W-1:0] sat_coord(input logic [QUOT_W-1:0] q,
                                                     input logic neg);
        logic [COORD_W-1:0] m;
        if (neg) begin
            m = (q > NEG_MAX_MAG) ? NEG_MAX_MAG[COORD_W-1:0] : q[COORD_W-1:0];
            return -m;
        end
        return (q > POS_MAX_MAG) ? POS_MAX_MAG[COORD_W-1:0] : q[COORD_W-1:0];
    endfunction

    // ---------------------------------------------------------------- handshake
    logic r1_v, r2_v, r3_v, r4_v;
    logic en1, en2, en3, en4;

    assign en4 = !r4_v || o_pt.ready;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign i_pix.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_pix.valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // full-image pixel in Q12.4, distance from the optical centre
    logic [P16_W-1:0] p16_x, p16_y;
    logic             n_neg_x, n_neg_y;
    logic [P16_W-1:0] n_mag_x, n_mag_y;

    always_comb begin
        p16_x   = {PIXEL_W'(r_x_offset) + PIXEL_W'(i_pix.win_col), 4'b0000};
        p16_y   = {PIXEL_W'(r_y_offset) + PIXEL_W'(i_pix.win_row), 4'b0000};
        n_neg_x = p16_x < P16_W'(r_center_x);
        n_neg_y = p16_y < P16_W'(r_center_y);
        n_mag_x = n_neg_x ? (P16_W'(r_center_x) - p16_x) : (p16_x - P16_W'(r_center_x));
        n_mag_y = n_neg_y ? (P16_W'(r_center_y) - p16_y) : (p16_y - P16_W'(r_center_y));
    end

    logic               r1_neg_x, r1_neg_y;
    logic [P16_W-1:0]   r1_mag_x, r1_mag_y;
    logic [DEPTH_W-1:0] r1_depth;
    logic               r1_ok, r1_dnz;
    logic [NUM_W-1:0]   r1_num;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_neg_x <= n_neg_x;
            r1_neg_y <= n_neg_y;
            r1_mag_x <= n_mag_x;
            r1_mag_y <= n_mag_y;
            r1_depth <= i_pix.depth_mm;
            r1_ok    <= i_pix.depth_mm > MIN_VALID_DEPTH;
            r1_dnz   <= i_pix.depth_mm != '0;
            // depth * 255
            r1_num   <= {i_pix.depth_mm, 8'h00} - NUM_W'(i_pix.depth_mm);
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic               r2_neg_x, r2_neg_y;
    logic [PM_W-1:0]    r2_pm_x, r2_pm_y;
    logic [DEPTH_W-1:0] r2_depth;
    logic               r2_ok, r2_dnz;
    t_div               r2_div;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_neg_x <= r1_neg_x;
            r2_neg_y <= r1_neg_y;
            r2_pm_x  <= PM_W'(r1_mag_x) * PM_W'(r_inv_focal_x);
            r2_pm_y  <= PM_W'(r1_mag_y) * PM_W'(r_inv_focal_y);
            r2_depth <= r1_depth;
            r2_ok    <= r1_ok;
            r2_dnz   <= r1_dnz;
            r2_div   <= div3(t_div'{rem: r1_num, quo: '0}, r_display_max, 4'd8);
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic               r3_neg_x, r3_neg_y;
    logic [FULL_W-1:0]  r3_full_x, r3_full_y;
    logic [DEPTH_W-1:0] r3_depth;
    logic               r3_ok, r3_dnz;
    t_div               r3_div;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_neg_x  <= r2_neg_x;
            r3_neg_y  <= r2_neg_y;
            r3_full_x <= FULL_W'(r2_pm_x) * FULL_W'(r2_depth);
            r3_full_y <= FULL_W'(r2_pm_y) * FULL_W'(r2_depth);
            r3_depth  <= r2_depth;
            r3_ok     <= r2_ok;
            r3_dnz    <= r2_dnz;
            r3_div    <= div3(r2_div, r_display_max, 4'd5);
        end
    end

    // ---------------------------------------------------------------- stage 4
    t_div               fin_div;
    logic [LEVEL_W-1:0] n_level;

    always_comb begin
        fin_div = div3(r3_div, r_display_max, 4'd2);
        // quotient of 256 or more clamps; a zero divisor lands here too
        if (fin_div.quo[DQ_W-1]) begin
            n_level = r3_dnz ? '1 : '0;
        end else begin
            n_level = fin_div.quo[LEVEL_W-1:0];
        end
    end

    logic signed [COORD_W-1:0] r_pos_x, r_pos_y;
    logic [DEPTH_W-1:0]        r_pos_z;
    logic                      r_point_valid;
    logic [LEVEL_W-1:0]        r_level;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_pos_x       <= r3_ok ? sat_coord(r3_full_x[FULL_W-1:INVF_W], r3_neg_x) : '0;
            r_pos_y       <= r3_ok ? sat_coord(r3_full_y[FULL_W-1:INVF_W], r3_neg_y) : '0;
            r_pos_z       <= r3_ok ? r3_depth : '0;
            r_point_valid <= r3_ok;
            r_level       <= n_level;
        end
    end

    assign o_pt.valid         = r4_v;
    assign o_pt.pos_x         = r_pos_x;
    assign o_pt.pos_y         = r_pos_y;
    assign o_pt.pos_z         = r_pos_z;
    assign o_pt.point_valid   = r_point_valid;
    assign o_pt.display_level = r_level;

endmodule

`default_nettype wire

>>> verif/tb_depth_pixel_to_point.sv
// Self-checking bench for depth_pixel_to_point: random pixel traffic under
// several calibrations, results checked against an in-bench back-projection.
// Depends on dpp_pkg, dpp_in_if, dpp_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb_depth_pixel_to_point;
    import dpp_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [DEPTH_W-1:0]  depth_mm;
        logic [PIXIDX_W-1:0] win_col;
        logic [PIXIDX_W-1:0] win_row;
    } t_pixel;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [DEPTH_W-1:0]        pos_z;
        logic                      point_valid;
        logic [LEVEL_W-1:0]        display_level;
    } t_point;

    typedef struct {
        logic [OFFSET_W-1:0] x_offset;
        logic [OFFSET_W-1:0] y_offset;
        logic [CENTRE_W-1:0] center_x;
        logic [CENTRE_W-1:0] center_y;
        logic [INVF_W-1:0]   inv_focal_x;
        logic [INVF_W-1:0]   inv_focal_y;
        logic [DMAX_W-1:0]   display_max;
    } t_calib;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    dpp_in_if  pix_if ();
    dpp_out_if pt_if ();

    t_calib      calib;
    t_pixel      pending_pixels [$];
    t_point      expected_points [$];
    int unsigned fail_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    depth_pixel_to_point uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_pt    (pt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // One axis: truncate toward zero, then saturate to the signed coordinate range.
    function automatic logic [COORD_W-1:0] back_project(input longint unsigned pixel,
                                                        input longint unsigned centre,
                                                        input longint unsigned inv,
                                                        input longint unsigned depth);
        longint unsigned p16;
        longint unsigned q;
        p16 = pixel << 4;
        if (p16 >= centre) begin
            q = ((p16 - centre) * inv * depth) >> 24;
            if (q > POS_MAX_MAG)
                q = POS_MAX_MAG;
            return q[COORD_W-1:0];
        end
        q = ((centre - p16) * inv * depth) >> 24;
        if (q > NEG_MAX_MAG)
            q = NEG_MAX_MAG;
        return COORD_W'(-q);
    endfunction

    function automatic t_point predict_point(input logic [DEPTH_W-1:0] depth,
                                             input logic [PIXIDX_W-1:0] col,
                                             input logic [PIXIDX_W-1:0] row);
        t_point      pt;
        int unsigned level;
        pt = '0;
        if (depth > MIN_VALID_DEPTH) begin
            pt.pos_x = back_project(64'(calib.x_offset) + 64'(col), 64'(calib.center_x),
                                    64'(calib.inv_focal_x), 64'(depth));
            pt.pos_y = back_project(64'(calib.y_offset) + 64'(row), 64'(calib.center_y),
                                    64'(calib.inv_focal_y), 64'(depth));
            pt.pos_z = depth;
            pt.point_valid = 1'b1;
        end
        if (calib.display_max == 0) begin
            pt.display_level = (depth != 0) ? 8'd255 : 8'd0;
        end else begin
            level = 32'(depth) * 255 / calib.display_max;
            pt.display_level = (level > 255) ? 8'd255 : level[LEVEL_W-1:0];
        end
        return pt;
    endfunction

    // append one pixel to the tail of the pending queue
    function automatic void queue_pixel(input logic [DEPTH_W-1:0] depth,
                                        input logic [PIXIDX_W-1:0] col,
                                        input logic [PIXIDX_W-1:0] row);
        pending_pixels.insert(pending_pixels.size(), t_pixel'{depth, col, row});
    endfunction

    task automatic report_field(input string fname, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // the block keeps only the low bits of each register
        case (idx)
            REG_X_OFFSET:    calib.x_offset    = value[OFFSET_W-1:0];
            REG_Y_OFFSET:    calib.y_offset    = value[OFFSET_W-1:0];
            REG_CENTER_X:    calib.center_x    = value[CENTRE_W-1:0];
            REG_CENTER_Y:    calib.center_y    = value[CENTRE_W-1:0];
            REG_INV_FOCAL_X: calib.inv_focal_x = value[INVF_W-1:0];
            REG_INV_FOCAL_Y: calib.inv_focal_y = value[INVF_W-1:0];
            REG_DISPLAY_MAX: calib.display_max = value[DMAX_W-1:0];
            default: ;
        endcase
    endtask

    // Pixel driver: predict on each accepted transaction, then offer the next one.
    always @(posedge i_clk) begin
        t_pixel next_pix;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready)
                expected_points.insert(expected_points.size(),
                                       predict_point(pix_if.depth_mm, pix_if.win_col,
                                                     pix_if.win_row));
            if (!pix_if.valid || pix_if.ready) begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_pix = pending_pixels.pop_front();
                    pix_if.valid    <= 1'b1;
                    pix_if.depth_mm <= next_pix.depth_mm;
                    pix_if.win_col  <= next_pix.win_col;
                    pix_if.win_row  <= next_pix.win_row;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        pt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Point monitor
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            if (expected_points.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected point, expected none, actual x=%0d y=%0d z=%0d",
                         $time, pt_if.pos_x, pt_if.pos_y, pt_if.pos_z);
            end else begin
                want = expected_points.pop_front();
                report_field("pos_x", longint'($signed(want.pos_x)), longint'(pt_if.pos_x));
                report_field("pos_y", longint'($signed(want.pos_y)), longint'(pt_if.pos_y));
                report_field("pos_z", longint'(want.pos_z), longint'(pt_if.pos_z));
                report_field("point_valid", longint'(want.point_valid),
                             longint'(pt_if.point_valid));
                report_field("display_level", longint'(want.display_level),
                             longint'(pt_if.display_level));
            end
        end
    end

    initial begin
        logic [DEPTH_W-1:0] directed_depths [12];
        logic [APB_DW-1:0]  cfg [7];
        logic [DEPTH_W-1:0] d;
        directed_depths = '{16'd0, 16'd1, 16'd99, 16'd100, 16'd101, 16'd102,
                            16'd4095, 16'd4096, 16'd4097, 16'd8191, 16'd65534, 16'd65535};
        calib.x_offset    = X_OFFSET_RST;
        calib.y_offset    = Y_OFFSET_RST;
        calib.center_x    = CENTER_X_RST;
        calib.center_y    = CENTER_Y_RST;
        calib.inv_focal_x = INV_FOCAL_X_RST;
        calib.inv_focal_y = INV_FOCAL_Y_RST;
        calib.display_max = DISPLAY_MAX_RST;
        pix_if.valid    = 1'b0;
        pix_if.depth_mm = '0;
        pix_if.win_col  = '0;
        pix_if.win_row  = '0;
        pt_if.ready     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 16 : (ph < 6) ? 61 : 0;
            recv_idle_pct = (ph < 3) ? 61 : (ph < 6) ? 16 : 0;
            case (ph)
                1: cfg = '{default: 32'd0};
                2: cfg = '{default: 32'hFFFF_FFFF};
                3: cfg = '{32'h7FF, 32'd0, 32'd0, 32'h7FFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'd1};
                4, 5: cfg = '{$urandom_range(0, 1664), $urandom_range(0, 824),
                              $urandom_range(0, 32767), $urandom_range(0, 32767),
                              $urandom_range(1, 65535), $urandom_range(1, 65535),
                              $urandom_range(1, 65535)};
                default: cfg = '{$urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom()};
            endcase
            if (ph > 0) begin
                for (int r = 0; r < 7; r++)
                    write_reg(r[2:0], cfg[r]);
                if (ph >= 4)
                    write_reg(REG_UNUSED, $urandom());
            end
            if (ph == 0) begin
                foreach (directed_depths[i]) begin
                    queue_pixel(directed_depths[i], 8'd0, 8'd255);
                    queue_pixel(directed_depths[i], 8'd255, 8'd0);
                end
            end
            // window corners at zero, threshold and full-scale depth
            for (int i = 0; i < 4; i++) begin
                d = (i == 0) ? 16'd0 : (i == 1) ? 16'd100 : (i == 2) ? 16'd101 : 16'hFFFF;
                queue_pixel(d, i[0] ? 8'd255 : 8'd0, i[1] ? 8'd255 : 8'd0);
            end
            for (int i = 0; i < 68; i++) begin
                case ($urandom_range(9))
                    0:       d = DEPTH_W'($urandom_range(0, 100));
                    1:       d = DEPTH_W'($urandom_range(99, 102));
                    2:       d = DEPTH_W'(32'hFFFF - $urandom_range(0, 3));
                    default: d = DEPTH_W'($urandom_range(0, 65535));
                endcase
                queue_pixel(d, PIXIDX_W'($urandom_range(0, 255)),
                            PIXIDX_W'($urandom_range(0, 255)));
            end
            // drain before touching the registers again
            while (pending_pixels.size() != 0 || pix_if.valid || expected_points.size() != 0)
                @(posedge i_clk);
            repeat (6) @(posedge i_clk);
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
